// ===== rtl/drwq_pkg.sv =====
// ----------------------------------------------------------------------------
// drwq_pkg
// Shared types and constants of the delayed register write queue: slot pool
// sizing, register address map, strobe codes and controller/datapath links.
// ----------------------------------------------------------------------------
package drwq_pkg;

  localparam int SLOT_COUNT  = 8;
  localparam int MAX_RESULTS = 8;
  localparam int SLOT_IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Register addresses decoded at commit.
  localparam logic [5:0] ADDR_VBLANK = 6'h01;
  localparam logic [5:0] ADDR_REFP0  = 6'h0b;
  localparam logic [5:0] ADDR_REFP1  = 6'h0c;
  localparam logic [5:0] ADDR_PF0    = 6'h0d;
  localparam logic [5:0] ADDR_PF1    = 6'h0e;
  localparam logic [5:0] ADDR_PF2    = 6'h0f;
  localparam logic [5:0] ADDR_GRP0   = 6'h1b;
  localparam logic [5:0] ADDR_GRP1   = 6'h1c;
  localparam logic [5:0] ADDR_ENAM0  = 6'h1d;
  localparam logic [5:0] ADDR_ENAM1  = 6'h1e;
  localparam logic [5:0] ADDR_ENABL  = 6'h1f;
  localparam logic [5:0] ADDR_HMP0   = 6'h20;
  localparam logic [5:0] ADDR_HMP1   = 6'h21;
  localparam logic [5:0] ADDR_HMM0   = 6'h22;
  localparam logic [5:0] ADDR_HMM1   = 6'h23;
  localparam logic [5:0] ADDR_HMBL   = 6'h24;
  localparam logic [5:0] ADDR_HMOVE  = 6'h2a;
  localparam logic [5:0] ADDR_HMCLR  = 6'h2b;

  // Bit positions in the flag register.
  localparam int FLAG_VBLANK = 0;
  localparam int FLAG_REFP0  = 1;
  localparam int FLAG_REFP1  = 2;
  localparam int FLAG_ENAM0  = 3;
  localparam int FLAG_ENAM1  = 4;
  localparam int FLAG_ENABL  = 5;

  typedef enum logic [2:0] {
    STB_NONE      = 3'd0,
    STB_GRP0      = 3'd1,
    STB_GRP1      = 3'd2,
    STB_HMOVE     = 3'd3,
    STB_HMCLR     = 3'd4,
    STB_UNHANDLED = 3'd5
  } drwq_strobe_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_TICK  = 1'b1
  } drwq_req_t;

  typedef enum logic {
    KIND_RESPONSE = 1'b0,
    KIND_COMMIT   = 1'b1
  } drwq_kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } drwq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  wr_req;  // queue the request on the input port
    logic                  commit;  // commit slot idx and emit its result
    logic                  hold;    // due slot over the per-tick limit: keep at 1
    logic                  dec;     // count slot idx down by one
    logic                  last;    // emitted commit is the last of this tick
    logic [SLOT_IDX_W-1:0] idx;     // slot under scan
  } drwq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cur_valid;  // slot idx holds a write
    logic cur_due;    // slot idx is due on this tick
    logic due_above;  // a slot above idx is due on this tick
    logic out_free;   // result register can load this cycle
  } drwq_sts_t;

endpackage

// ===== rtl/drwq_ctrl.sv =====
// ----------------------------------------------------------------------------
// drwq_ctrl
// Controller: takes requests, and on each tick walks the slot pool one slot a
// cycle, held on a due slot by a full output, issuing count-down and commit commands.
// ----------------------------------------------------------------------------
module drwq_ctrl
  import drwq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  drwq_req_t   in_type,
  output logic        in_ready,
  input  drwq_sts_t   sts,
  output drwq_cmd_t   cmd,
  output drwq_state_t state
);

  drwq_state_t           state_r, state_nxt;
  logic [SLOT_IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    in_ready   = 1'b0;
    advance    = 1'b0;
    cmd        = '0;
    cmd.idx    = idx_r;
    cmd.last   = (count_r == CNT_W'(MAX_RESULTS - 1)) || !sts.due_above;
    case (state_r)
      ST_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          if (in_type == REQ_WRITE) begin
            cmd.wr_req = 1'b1;
          end else begin
            state_nxt = ST_SCAN;
            idx_nxt   = '0;
            count_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        if (sts.cur_valid && sts.cur_due) begin
          if (count_r >= CNT_W'(MAX_RESULTS)) begin
            cmd.hold = 1'b1;
            advance  = 1'b1;
          end else if (sts.out_free) begin
            cmd.commit = 1'b1;
            count_nxt  = count_r + CNT_W'(1);
            advance    = 1'b1;
          end
        end else begin
          cmd.dec = sts.cur_valid;
          advance = 1'b1;
        end
        if (advance) begin
          if (idx_r == SLOT_IDX_W'(SLOT_COUNT - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + SLOT_IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign state = state_r;

endmodule

// ===== rtl/drwq_datapath.sv =====
// ----------------------------------------------------------------------------
// drwq_datapath
// Datapath: slot pool, address decode into the kept registers, and the
// result register that parts the controller from the output channel.
// ----------------------------------------------------------------------------
module drwq_datapath
  import drwq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  drwq_cmd_t    cmd,
  output drwq_sts_t    sts,
  input  logic [5:0]   in_address,
  input  logic [7:0]   in_data,
  input  logic [6:0]   in_delay,
  output logic         out_valid,
  input  logic         out_ready,
  output drwq_kind_t   out_kind,
  output logic         out_accepted,
  output logic [5:0]   out_address,
  output logic [7:0]   out_data,
  output drwq_strobe_t out_strobe,
  output logic [19:0]  out_playfield,
  output logic [5:0]   out_flags,
  output logic [19:0]  out_offsets,
  output logic         out_last
);

  logic [SLOT_COUNT-1:0] valid_r;
  logic [5:0]            addr_r [SLOT_COUNT];
  logic [7:0]            data_r [SLOT_COUNT];
  logic [6:0]            cd_r   [SLOT_COUNT];

  logic [19:0] pf_r, pf_nxt;
  logic [5:0]  fl_r, fl_nxt;
  logic [19:0] off_r, off_nxt;

  logic                  out_valid_r;
  drwq_kind_t            kind_r;
  logic                  acc_r;
  logic [5:0]            oaddr_r;
  logic [7:0]            odata_r;
  drwq_strobe_t          strobe_r, strobe_nxt;
  logic [19:0]           opf_r;
  logic [5:0]            ofl_r;
  logic [19:0]           ooff_r;
  logic                  olast_r;

  logic                  free_found;
  logic [SLOT_IDX_W-1:0] free_idx;
  logic [SLOT_COUNT-1:0] due;
  logic                  due_above;
  logic [5:0]            c_addr;
  logic [7:0]            c_data;
  logic [3:0]            nib;
  logic                  load;
  logic                  out_free;

  // Lowest free slot; descending walk so the lowest index wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    due_above = 1'b0;
    for (int j = 0; j < SLOT_COUNT; j++) begin
      due[j] = valid_r[j] && (cd_r[j] <= 7'd1);
      if (due[j] && (SLOT_IDX_W'(j) > cmd.idx)) begin
        due_above = 1'b1;
      end
    end
  end

  assign c_addr = addr_r[cmd.idx];
  assign c_data = data_r[cmd.idx];
  assign nib    = c_data[7:4];

  // Effect of committing the slot under scan on the kept registers.
  always_comb begin
    pf_nxt     = pf_r;
    fl_nxt     = fl_r;
    off_nxt    = off_r;
    strobe_nxt = STB_NONE;
    case (c_addr)
      ADDR_VBLANK: fl_nxt[FLAG_VBLANK] = c_data[1];
      ADDR_REFP0:  fl_nxt[FLAG_REFP0]  = c_data[3];
      ADDR_REFP1:  fl_nxt[FLAG_REFP1]  = c_data[3];
      ADDR_PF0:    pf_nxt[3:0]         = nib;
      ADDR_PF1: begin
        // This byte lands bit-reversed in the playfield.
        for (int n = 0; n < 8; n++) begin
          pf_nxt[4 + n] = c_data[7 - n];
        end
      end
      ADDR_PF2:    pf_nxt[19:12]       = c_data;
      ADDR_GRP0:   strobe_nxt          = STB_GRP0;
      ADDR_GRP1:   strobe_nxt          = STB_GRP1;
      ADDR_ENAM0:  fl_nxt[FLAG_ENAM0]  = c_data[1];
      ADDR_ENAM1:  fl_nxt[FLAG_ENAM1]  = c_data[1];
      ADDR_ENABL:  fl_nxt[FLAG_ENABL]  = c_data[1];
      ADDR_HMP0:   off_nxt[3:0]        = nib;
      ADDR_HMP1:   off_nxt[7:4]        = nib;
      ADDR_HMM0:   off_nxt[11:8]       = nib;
      ADDR_HMM1:   off_nxt[15:12]      = nib;
      ADDR_HMBL:   off_nxt[19:16]      = nib;
      ADDR_HMOVE:  strobe_nxt          = STB_HMOVE;
      ADDR_HMCLR: begin
        off_nxt    = '0;
        strobe_nxt = STB_HMCLR;
      end
      default:     strobe_nxt          = STB_UNHANDLED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      pf_r    <= '0;
      fl_r    <= '0;
      off_r   <= '0;
    end else begin
      if (cmd.wr_req && free_found) begin
        valid_r[free_idx] <= 1'b1;
      end
      if (cmd.commit) begin
        valid_r[cmd.idx] <= 1'b0;
        pf_r             <= pf_nxt;
        fl_r             <= fl_nxt;
        off_r            <= off_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_req && free_found) begin
      addr_r[free_idx] <= in_address;
      data_r[free_idx] <= in_data;
      cd_r[free_idx]   <= (in_delay == 7'd0) ? 7'd1 : in_delay;
    end
    if (cmd.hold) begin
      cd_r[cmd.idx] <= 7'd1;
    end else if (cmd.dec) begin
      cd_r[cmd.idx] <= cd_r[cmd.idx] - 7'd1;
    end
  end

  assign load     = cmd.wr_req || cmd.commit;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      kind_r   <= KIND_COMMIT;
      acc_r    <= 1'b0;
      oaddr_r  <= c_addr;
      odata_r  <= c_data;
      strobe_r <= strobe_nxt;
      opf_r    <= pf_nxt;
      ofl_r    <= fl_nxt;
      ooff_r   <= off_nxt;
      olast_r  <= cmd.last;
    end else if (cmd.wr_req) begin
      kind_r   <= KIND_RESPONSE;
      acc_r    <= free_found;
      oaddr_r  <= '0;
      odata_r  <= '0;
      strobe_r <= STB_NONE;
      opf_r    <= pf_r;
      ofl_r    <= fl_r;
      ooff_r   <= off_r;
      olast_r  <= 1'b1;
    end
  end

  assign sts.cur_valid = valid_r[cmd.idx];
  assign sts.cur_due   = cd_r[cmd.idx] <= 7'd1;
  assign sts.due_above = due_above;
  assign sts.out_free  = out_free;

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_accepted  = acc_r;
  assign out_address   = oaddr_r;
  assign out_data      = odata_r;
  assign out_strobe    = strobe_r;
  assign out_playfield = opf_r;
  assign out_flags     = ofl_r;
  assign out_offsets   = ooff_r;
  assign out_last      = olast_r;

endmodule

// ===== rtl/delayed_register_write_queue_unit.sv =====
// Write request: once accepted, its response sits in the result register next cycle.
// Tick: once accepted, it starts a scan of the slot pool at one slot per cycle, which pauses
// on a due slot while the output holds off a commit.
// The scan length is set by the controller walking the slots through a single commit path.
// Reset (synchronous, rst_n low) empties every slot and clears the playfield, flag and motion
// offset registers; slot contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// delayed_register_write_queue_unit
// Pool of delayed register writes that count down on ticks and commit in slot
// order, decoding each commit into playfield, flag and motion-offset state.
// ----------------------------------------------------------------------------
module delayed_register_write_queue_unit
  import drwq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // reg_address[5:0], write_data[13:6], delay_ticks[20:14], zero
  input  logic        in_tuser,   // req_type: 0 write request, 1 tick
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // accepted[0], commit_address[6:1], commit_data[14:7],
                                  // strobe_code[17:15], playfield_bits[37:18],
                                  // control_flags[43:38], motion_offsets[63:44]
  output logic        out_tuser,  // result_kind: 0 request response, 1 commit
  output logic        out_tlast   // last_result
);

  // The controller and the datapath talk only through these two bundles.
  drwq_cmd_t    cmd;
  drwq_sts_t    sts;
  drwq_state_t  state;

  drwq_kind_t   res_kind;
  logic         res_accepted;
  logic [5:0]   res_address;
  logic [7:0]   res_data;
  drwq_strobe_t res_strobe;
  logic [19:0]  res_playfield;
  logic [5:0]   res_flags;
  logic [19:0]  res_offsets;

  // The controller accepts a request only while idle and while the result
  // register can take the response, so a write request never waits inside.
  drwq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_type  (drwq_req_t'(in_tuser)),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  // The datapath holds the slots and the decoded state, and owns the result
  // register that parts the scan from a stalled output.
  drwq_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_address    (in_tdata[5:0]),
    .in_data       (in_tdata[13:6]),
    .in_delay      (in_tdata[20:14]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_kind      (res_kind),
    .out_accepted  (res_accepted),
    .out_address   (res_address),
    .out_data      (res_data),
    .out_strobe    (res_strobe),
    .out_playfield (res_playfield),
    .out_flags     (res_flags),
    .out_offsets   (res_offsets),
    .out_last      (out_tlast)
  );

  assign out_tuser = res_kind;
  assign out_tdata = {res_offsets, res_flags, res_playfield, res_strobe,
                      res_data, res_address, res_accepted};

  // A request response is always the only result of its request.
  a_response_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_RESPONSE) |-> out_tlast)
    else $error("request response without last marker");

  // Commits never claim to have taken a slot.
  a_commit_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_COMMIT) |-> !out_tdata[0])
    else $error("commit result flagged as accepted");

  // No new request is taken while a tick scan is running.
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state == ST_SCAN) |-> !in_tready)
    else $error("request accepted during a scan");

  // A commit never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_tvalid || out_tready))
    else $error("commit issued onto an occupied result register");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the delayed register write queue: a directed run
// of write and tick requests, then random traffic, every result compared
// with an in-bench predictor of the slot pool and the decoded registers.
// ----------------------------------------------------------------------------
module testbench;
  import drwq_pkg::*;

  localparam int RAND_REQUESTS = 330;
  localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int HOLD_AFTER    = 40;      // results checked before the hold-off
  localparam int DRAIN_CYCLES  = 2 * (SLOT_COUNT + 1) + 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;

  // One result as it leaves the block, unpacked into its fields.
  typedef struct packed {
    drwq_kind_t   kind;
    logic         acc;
    logic [5:0]   addr;
    logic [7:0]   data;
    drwq_strobe_t strobe;
    logic [19:0]  pf;
    logic [5:0]   flags;
    logic [19:0]  offs;
    logic         last;
  } queue_result_t;

  // One row of the directed part; typed rows carry their single result.
  typedef struct {
    drwq_req_t     kind;
    logic [5:0]    addr;
    logic [7:0]    data;
    logic [6:0]    dly;
    logic          typed;
    queue_result_t res;
  } request_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  delayed_register_write_queue_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the slot pool and the three decoded registers.
  logic        slot_busy [SLOT_COUNT];
  logic [5:0]  slot_addr [SLOT_COUNT];
  logic [7:0]  slot_data [SLOT_COUNT];
  logic [6:0]  slot_ticks [SLOT_COUNT];
  logic [19:0] pf_state = '0;
  logic [5:0]  flag_state = '0;
  logic [19:0] hm_state = '0;

  queue_result_t step_results[$];     // results of the request just predicted
  queue_result_t pending_results[$];  // results still owed by the block

  // Typed expectation of the request currently on offer, if any.
  logic          drv_typed = 1'b0;
  queue_result_t drv_typed_res;

  int mismatch_count  = 0;
  int results_checked = 0;
  int commits_seen    = 0;
  int writes_sent     = 0;
  int ticks_sent      = 0;
  int refused_writes  = 0;
  int cycle_count     = 0;
  int burst_left      = 0;
  logic [5:0] strobe_seen = '0;

  // Addresses the decoder acts on; random writes favour these.
  logic [5:0] known_addrs [18] = '{
    ADDR_VBLANK, ADDR_REFP0, ADDR_REFP1, ADDR_PF0, ADDR_PF1, ADDR_PF2,
    ADDR_GRP0, ADDR_GRP1, ADDR_ENAM0, ADDR_ENAM1, ADDR_ENABL, ADDR_HMP0,
    ADDR_HMP1, ADDR_HMM0, ADDR_HMM1, ADDR_HMBL, ADDR_HMOVE, ADDR_HMCLR
  };

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_busy[i]  = 1'b0;
      slot_addr[i]  = '0;
      slot_data[i]  = '0;
      slot_ticks[i] = '0;
    end
  end

  // Decodes one committed write into the kept registers and returns its strobe.
  function automatic drwq_strobe_t commit_register(input logic [5:0] a, input logic [7:0] d);
    int lane;
    lane = (int'(a) - int'(ADDR_HMP0)) * 4;
    case (a)
      ADDR_VBLANK: flag_state[FLAG_VBLANK] = d[1];
      ADDR_REFP0:  flag_state[FLAG_REFP0]  = d[3];
      ADDR_REFP1:  flag_state[FLAG_REFP1]  = d[3];
      ADDR_ENAM0:  flag_state[FLAG_ENAM0]  = d[1];
      ADDR_ENAM1:  flag_state[FLAG_ENAM1]  = d[1];
      ADDR_ENABL:  flag_state[FLAG_ENABL]  = d[1];
      ADDR_PF0:    pf_state[3:0] = d[7:4];
      // The middle playfield byte lands in reversed bit order.
      ADDR_PF1: for (int n = 0; n < 8; n++) pf_state[4 + n] = d[7 - n];
      ADDR_PF2:    pf_state[19:12] = d;
      ADDR_HMP0, ADDR_HMP1, ADDR_HMM0, ADDR_HMM1, ADDR_HMBL:
        hm_state[lane +: 4] = d[7:4];
      ADDR_GRP0:   return STB_GRP0;
      ADDR_GRP1:   return STB_GRP1;
      ADDR_HMOVE:  return STB_HMOVE;
      ADDR_HMCLR: begin
        hm_state = '0;
        return STB_HMCLR;
      end
      default:     return STB_UNHANDLED;
    endcase
    return STB_NONE;
  endfunction

  // Advances the predicted pool by one accepted request and fills step_results.
  task automatic apply_queue_request(input drwq_req_t kind, input logic [5:0] a,
                                     input logic [7:0] d, input logic [6:0] dly);
    int free_slot;
    int emitted;
    drwq_strobe_t s;
    step_results.delete();
    if (kind == REQ_WRITE) begin
      writes_sent++;
      free_slot = -1;
      for (int i = 0; i < SLOT_COUNT; i++)
        if (!slot_busy[i] && free_slot < 0) free_slot = i;
      if (free_slot >= 0) begin
        slot_busy[free_slot]  = 1'b1;
        slot_addr[free_slot]  = a;
        slot_data[free_slot]  = d;
        // A zero delay would otherwise wrap; it means the next tick.
        slot_ticks[free_slot] = (dly == 7'd0) ? 7'd1 : dly;
      end else begin
        refused_writes++;
      end
      step_results.push_back('{KIND_RESPONSE, free_slot >= 0, 6'd0, 8'd0, STB_NONE,
                               pf_state, flag_state, hm_state, 1'b1});
    end else begin
      ticks_sent++;
      emitted = 0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (slot_busy[i]) begin
          if (slot_ticks[i] <= 7'd1) begin
            if (emitted >= MAX_RESULTS) begin
              slot_ticks[i] = 7'd1;   // over the per-tick limit: due again next tick
            end else begin
              s = commit_register(slot_addr[i], slot_data[i]);
              strobe_seen[s] = 1'b1;
              slot_busy[i] = 1'b0;
              step_results.push_back('{KIND_COMMIT, 1'b0, slot_addr[i], slot_data[i], s,
                                       pf_state, flag_state, hm_state, 1'b0});
              emitted++;
            end
          end else begin
            slot_ticks[i] = slot_ticks[i] - 7'd1;
          end
        end
      end
      if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    end
  endtask

  function automatic bit field_differs(input string name, input logic [19:0] want,
                                       input logic [19:0] got);
    if (want === got) return 1'b0;
    if (mismatch_count < REPORT_LIMIT)
      $display("  result %0d field %s: expected 0x%0h, got 0x%0h",
               results_checked, name, want, got);
    return 1'b1;
  endfunction

  // Result checking and request prediction, both at the rising edge.
  always @(posedge clk) begin : scoreboard
    queue_result_t got;
    queue_result_t want;
    bit bad;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.kind   = drwq_kind_t'(out_tuser);
        got.acc    = out_tdata[0];
        got.addr   = out_tdata[6:1];
        got.data   = out_tdata[14:7];
        got.strobe = drwq_strobe_t'(out_tdata[17:15]);
        got.pf     = out_tdata[37:18];
        got.flags  = out_tdata[43:38];
        got.offs   = out_tdata[63:44];
        got.last   = out_tlast;
        if (pending_results.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("Unexpected result at cycle %0d: kind %0d addr 0x%0h data 0x%0h",
                     cycle_count, got.kind, got.addr, got.data);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          bad = 1'b0;
          bad |= field_differs("result_kind", want.kind, got.kind);
          bad |= field_differs("accepted", want.acc, got.acc);
          bad |= field_differs("commit_address", want.addr, got.addr);
          bad |= field_differs("commit_data", want.data, got.data);
          bad |= field_differs("strobe_code", want.strobe, got.strobe);
          bad |= field_differs("playfield_bits", want.pf, got.pf);
          bad |= field_differs("control_flags", want.flags, got.flags);
          bad |= field_differs("motion_offsets", want.offs, got.offs);
          bad |= field_differs("last_result", want.last, got.last);
          if (bad) mismatch_count++;
          if (want.kind == KIND_COMMIT) commits_seen++;
        end
        results_checked++;
      end
      if (in_tvalid && in_tready) begin
        apply_queue_request(drwq_req_t'(in_tuser), in_tdata[5:0], in_tdata[13:6],
                            in_tdata[20:14]);
        if (drv_typed) pending_results.push_back(drv_typed_res);
        else foreach (step_results[k]) pending_results.push_back(step_results[k]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed",
               cycle_count, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offers one request from a falling edge and returns at the falling edge after
  // it was taken. Requests come in bursts with idle gaps between them.
  task automatic offer_request(input drwq_req_t kind, input logic [5:0] a,
                               input logic [7:0] d, input logic [6:0] dly,
                               input logic typed, input queue_result_t res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    drv_typed     = typed;
    drv_typed_res = res;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, dly, d, a};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic offer_write(input logic [5:0] a, input logic [7:0] d, input logic [6:0] dly);
    offer_request(REQ_WRITE, a, d, dly, 1'b0, '0);
  endtask

  task automatic offer_random_write(input logic [6:0] dly);
    logic [5:0] a;
    a = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                    : known_addrs[$urandom_range(0, 17)];
    offer_write(a, 8'($urandom_range(0, 255)), dly);
  endtask

  // Receiver: steps through four stall patterns and holds off once for
  // a long stretch so that the result register and then the input back up.
  initial begin : result_sink
    int rx_cycle;
    bit hold_done;
    rx_cycle = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (!hold_done && results_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        case ((rx_cycle / 48) % 4)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 9) < 7);
          2:       out_tready <= (rx_cycle % 3 != 0);
          default: out_tready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  request_row_t directed_rows[$];

  function automatic request_row_t make_row(input drwq_req_t kind, input logic [5:0] a,
                                            input logic [7:0] d, input logic [6:0] dly);
    request_row_t r;
    r.kind  = kind;
    r.addr  = a;
    r.data  = d;
    r.dly   = dly;
    r.typed = 1'b0;
    r.res   = '0;
    return r;
  endfunction

  initial begin : request_source
    request_row_t r;
    int sent;
    int run;

    // Directed rows. The first three have results plain from reset: a zero delay
    // write to an address the decoder ignores, its commit, then an empty tick.
    r = make_row(REQ_WRITE, 6'h3f, 8'hff, 7'd0);
    r.typed = 1'b1;
    r.res = '{KIND_RESPONSE, 1'b1, 6'd0, 8'd0, STB_NONE, 20'd0, 6'd0, 20'd0, 1'b1};
    directed_rows.push_back(r);
    r = make_row(REQ_TICK, 6'd0, 8'd0, 7'd0);
    r.typed = 1'b1;
    r.res = '{KIND_COMMIT, 1'b0, 6'h3f, 8'hff, STB_UNHANDLED, 20'd0, 6'd0, 20'd0, 1'b1};
    directed_rows.push_back(r);
    directed_rows.push_back(make_row(REQ_TICK, 6'h3f, 8'hff, 7'h7f));
    // Fill all eight slots; every one is due on the next tick.
    directed_rows.push_back(make_row(REQ_WRITE, ADDR_PF1, 8'h96, 7'd1));
    directed_rows.push_back(make_row(REQ_WRITE, ADDR_PF0, 8'hf0, 7'd0));
    directed_rows.push_back(make_row(REQ_WRITE, ADDR_PF2, 8'ha5, 7'd1));
    directed_rows.push_back(make_row(REQ_WRITE, ADDR_VBLANK, 8'h02, 7'd1));
    directed_rows.push_back(make_row(REQ_WRITE, ADDR_HMP0, 8'hf0, 7'd1));
    directed_rows.push_back(make_row(REQ_WRITE, ADDR_GRP0, 8'h00, 7'd1));
    directed_rows.push_back(make_row(REQ_WRITE, ADDR_HMOVE, 8'h55, 7'd1));
    directed_rows.push_back(make_row(REQ_WRITE, ADDR_REFP0, 8'h08, 7'd1));
    // Pool full: the request is refused and nothing has changed the registers.
    r = make_row(REQ_WRITE, ADDR_ENABL, 8'h02, 7'd1);
    r.typed = 1'b1;
    r.res = '{KIND_RESPONSE, 1'b0, 6'd0, 8'd0, STB_NONE, 20'd0, 6'd0, 20'd0, 1'b1};
    directed_rows.push_back(r);
    // Eight commits on one tick, then the remaining operations.
    directed_rows.push_back(make_row(REQ_TICK, 6'd0, 8'd0, 7'd0));
    directed_rows.push_back(make_row(REQ_WRITE, ADDR_HMBL, 8'hff, 7'h7f));
    directed_rows.push_back(make_row(REQ_WRITE, ADDR_HMCLR, 8'h00, 7'd2));
    directed_rows.push_back(make_row(REQ_WRITE, ADDR_REFP1, 8'h08, 7'd3));
    directed_rows.push_back(make_row(REQ_WRITE, ADDR_ENAM0, 8'h02, 7'd2));
    directed_rows.push_back(make_row(REQ_WRITE, ADDR_ENAM1, 8'h02, 7'd2));
    directed_rows.push_back(make_row(REQ_WRITE, ADDR_GRP1, 8'h3c, 7'd1));
    directed_rows.push_back(make_row(REQ_TICK, 6'd0, 8'd0, 7'd0));
    directed_rows.push_back(make_row(REQ_TICK, 6'd0, 8'd0, 7'd0));
    directed_rows.push_back(make_row(REQ_TICK, 6'd0, 8'd0, 7'd0));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      offer_request(directed_rows[i].kind, directed_rows[i].addr, directed_rows[i].data,
                    directed_rows[i].dly, directed_rows[i].typed, directed_rows[i].res);

    // Random traffic: mostly short delays so that slots turn over, an occasional
    // long delay, runs of writes that fill the pool and runs of ticks that drain it.
    sent = 0;
    while (sent < RAND_REQUESTS) begin
      case ($urandom_range(0, 19))
        0: begin
          run = $urandom_range(4, 10);
          repeat (run) offer_random_write(7'($urandom_range(0, 3)));
          sent += run;
        end
        1: begin
          run = $urandom_range(3, 12);
          repeat (run) offer_request(REQ_TICK, 6'($urandom_range(0, 63)),
                                     8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                                     1'b0, '0);
          sent += run;
        end
        2, 3, 4, 5, 6, 7, 8, 9: begin
          case ($urandom_range(0, 39))
            0:       offer_random_write(7'($urandom_range(0, 127)));
            1, 2, 3: offer_random_write(7'($urandom_range(0, 40)));
            default: offer_random_write(7'($urandom_range(0, 5)));
          endcase
          sent++;
        end
        default: begin
          offer_request(REQ_TICK, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                        7'($urandom_range(0, 127)), 1'b0, '0);
          sent++;
        end
      endcase
    end
    in_tvalid <= 1'b0;

    // Wait for every owed result, then DRAIN_CYCLES more for anything stray.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d write requests (%0d refused with the pool full) and %0d ticks.",
             writes_sent, refused_writes, ticks_sent);
    $display("Checked %0d results, %0d of them commits; strobe kinds seen 6'b%b.",
             results_checked, commits_seen, strobe_seen);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               mismatch_count, pending_results.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
